### src/dwfb_pkg.sv
// ----------------------------------------------------------------------------
// dwfb_pkg
// Shared types and constants of the dual write FIFO with bypass.
// ----------------------------------------------------------------------------
package dwfb_pkg;

  localparam int WORD_W         = 32;
  localparam int COUNT_W        = 5;
  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int APB_ADDR_W     = 3;
  localparam int APB_DATA_W     = 32;

  // Register word index, taken from paddr above the byte offset.
  localparam logic REG_EMPTY_VALUE = 1'b0;

  typedef struct packed {
    logic              write_valid_a;
    logic [WORD_W-1:0] write_data_a;
    logic              write_valid_b;
    logic [WORD_W-1:0] write_data_b;
    logic              read_enable;
    logic              update_enable;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0]  read_data;
    logic [COUNT_W-1:0] entry_count;
    logic               is_full;
    logic               data_available;
  } result_t;

endpackage

### src/dwfb_item_if.sv
// ----------------------------------------------------------------------------
// dwfb_item_if
// Valid/ready channel carrying one write/read request item.
// ----------------------------------------------------------------------------
interface dwfb_item_if;
  import dwfb_pkg::*;

  logic              valid;
  logic              ready;
  logic              write_valid_a;
  logic [WORD_W-1:0] write_data_a;
  logic              write_valid_b;
  logic [WORD_W-1:0] write_data_b;
  logic              read_enable;
  logic              update_enable;

  modport source (
    output valid, write_valid_a, write_data_a, write_valid_b, write_data_b,
           read_enable, update_enable,
    input  ready
  );

  modport sink (
    input  valid, write_valid_a, write_data_a, write_valid_b, write_data_b,
           read_enable, update_enable,
    output ready
  );
endinterface

### src/dwfb_result_if.sv
// ----------------------------------------------------------------------------
// dwfb_result_if
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface dwfb_result_if;
  import dwfb_pkg::*;

  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  read_data;
  logic [COUNT_W-1:0] entry_count;
  logic               is_full;
  logic               data_available;

  modport source (
    output valid, read_data, entry_count, is_full, data_available,
    input  ready
  );

  modport sink (
    input  valid, read_data, entry_count, is_full, data_available,
    output ready
  );
endinterface

### src/dual_write_fifo_with_bypass.sv
// ----------------------------------------------------------------------------
// dual_write_fifo_with_bypass
// FIFO with two write ports, one read port and empty-queue read bypass.
// ----------------------------------------------------------------------------
// Each request item is captured in an input register; the queue update and
// the result are computed from it in one pass and land in the result
// register when the item advances, which waits while a result is held, and one
// item is taken every cycle while results are drained. The entries live
// in flip-flops whose head is read through a multiplexer, with forwarding of
// writes that land at the new head in the same cycle.
module dual_write_fifo_with_bypass #(
  parameter int CAPACITY   = dwfb_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = dwfb_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  dwfb_item_if.sink                       cmd,
  dwfb_result_if.source                   result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dwfb_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [dwfb_pkg::APB_DATA_W-1:0] pwdata,
  output logic [dwfb_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import dwfb_pkg::*;

  logic              in_valid;
  item_t             in_item;
  logic              advance;
  logic              out_valid;
  result_t           out_data;
  result_t           step_result;
  logic [WORD_W-1:0] empty_value;

  assign advance   = in_valid && (!out_valid || result.ready);
  assign cmd.ready = !in_valid || !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      in_valid <= (cmd.valid && cmd.ready) || (in_valid && !advance);
      if (advance) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_item.write_valid_a <= cmd.write_valid_a;
      in_item.write_data_a  <= cmd.write_data_a;
      in_item.write_valid_b <= cmd.write_valid_b;
      in_item.write_data_b  <= cmd.write_data_b;
      in_item.read_enable   <= cmd.read_enable;
      in_item.update_enable <= cmd.update_enable;
    end
    if (advance) begin
      out_data <= step_result;
    end
  end

  assign result.valid          = out_valid;
  assign result.read_data      = out_data.read_data;
  assign result.entry_count    = out_data.entry_count;
  assign result.is_full        = out_data.is_full;
  assign result.data_available = out_data.data_available;

  dwfb_apb u_apb (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .empty_value (empty_value)
  );

  dwfb_queue #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .item        (in_item),
    .commit      (advance),
    .empty_value (empty_value),
    .result      (step_result)
  );

endmodule

### src/dwfb_apb.sv
// ----------------------------------------------------------------------------
// dwfb_apb
// APB register block holding the empty value register.
// ----------------------------------------------------------------------------
module dwfb_apb (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dwfb_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [dwfb_pkg::APB_DATA_W-1:0] pwdata,
  output logic [dwfb_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output logic [dwfb_pkg::WORD_W-1:0]     empty_value
);
  import dwfb_pkg::*;

  logic reg_index;
  logic wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[APB_ADDR_W-1];
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      empty_value <= '0;
    end else if (wr_en && reg_index == REG_EMPTY_VALUE) begin
      empty_value <= WORD_W'(pwdata);
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_index == REG_EMPTY_VALUE) begin
      prdata = APB_DATA_W'(empty_value);
    end
  end

endmodule

### src/dwfb_queue.sv
// ----------------------------------------------------------------------------
// dwfb_queue
// Queue state, entry store and the single-pass update for one item.
// ----------------------------------------------------------------------------
module dwfb_queue #(
  parameter int CAPACITY   = dwfb_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = dwfb_pkg::DATA_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dwfb_pkg::item_t             item,
  input  logic                        commit,
  input  logic [dwfb_pkg::WORD_W-1:0] empty_value,
  output dwfb_pkg::result_t           result
);
  import dwfb_pkg::*;

  localparam int PTR_W = $clog2(CAPACITY);
  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam logic [OCC_W-1:0] OCC_CAP = OCC_W'(CAPACITY);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);

  logic [DATA_WIDTH-1:0] store [CAPACITY];
  logic [PTR_W-1:0]      head;
  logic [PTR_W-1:0]      tail;
  logic [OCC_W-1:0]      occ;

  logic                  first_valid;
  logic                  second_valid;
  logic [DATA_WIDTH-1:0] first_data;
  logic [DATA_WIDTH-1:0] second_data;
  logic                  start_empty;
  logic                  pop;
  logic                  push_a;
  logic                  push_b;
  logic [OCC_W-1:0]      occ_pop;
  logic [OCC_W-1:0]      occ_a;
  logic [PTR_W-1:0]      tail_a;
  logic [PTR_W-1:0]      head_next;
  logic [PTR_W-1:0]      tail_next;
  logic [OCC_W-1:0]      occ_next;
  logic [DATA_WIDTH-1:0] head_data;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    first_valid  = item.write_valid_a || item.write_valid_b;
    second_valid = item.write_valid_a && item.write_valid_b;
    first_data   = DATA_WIDTH'(item.write_valid_a ? item.write_data_a : item.write_data_b);
    second_data  = DATA_WIDTH'(item.write_data_b);
    start_empty  = (occ == '0);

    pop       = item.update_enable && item.read_enable && !start_empty;
    occ_pop   = occ - OCC_W'(pop);
    head_next = pop ? ptr_inc(head) : head;

    push_a = item.update_enable && first_valid && !(start_empty && item.read_enable)
             && (occ_pop < OCC_CAP);
    occ_a  = occ_pop + OCC_W'(push_a);
    tail_a = push_a ? ptr_inc(tail) : tail;

    push_b    = item.update_enable && second_valid && (occ_a < OCC_CAP);
    occ_next  = occ_a + OCC_W'(push_b);
    tail_next = push_b ? ptr_inc(tail_a) : tail_a;

    priority if (push_a && tail == head_next) begin
      head_data = first_data;
    end else if (push_b && tail_a == head_next) begin
      head_data = second_data;
    end else begin
      head_data = store[head_next];
    end

    priority if (start_empty && first_valid) begin
      result.read_data = WORD_W'(first_data);
    end else if (occ_next == '0) begin
      result.read_data = empty_value;
    end else begin
      result.read_data = WORD_W'(head_data);
    end
    result.entry_count    = COUNT_W'(occ_next);
    result.is_full        = (occ_next >= OCC_CAP);
    result.data_available = (occ_next != '0) || first_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      occ  <= '0;
    end else if (commit) begin
      head <= head_next;
      tail <= tail_next;
      occ  <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && push_a) begin
      store[tail] <= first_data;
    end
    if (commit && push_b) begin
      store[tail_a] <= second_data;
    end
  end

endmodule

### dv/dual_write_fifo_with_bypass_test.sv
// ----------------------------------------------------------------------------
// dual_write_fifo_with_bypass_test
// Self-checking bench for the dual write FIFO with read bypass. A driver feeds
// request items from a queue, a monitor predicts every result from its own
// copy of the queue state and compares it with what the block returns, and
// the empty value register is reprogrammed between phases over the APB port.
// ----------------------------------------------------------------------------
module dual_write_fifo_with_bypass_test;
  import dwfb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = CAPACITY_DEF;
  localparam int HOLD_LEN   = 150;
  localparam int SETTLE     = 6;
  localparam int CHUNK      = 16;
  localparam logic [APB_ADDR_W-1:0] EMPTY_VALUE_ADDR = {REG_EMPTY_VALUE, 2'b00};

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  dwfb_item_if   cmd_ch ();
  dwfb_result_if result_ch ();

  dual_write_fifo_with_bypass dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  item_t   request_queue[$];
  result_t awaited_results[$];

  logic [WORD_W-1:0] shadow_entries [DEPTH];
  logic [3:0]        shadow_head;
  logic [3:0]        shadow_tail;
  int unsigned       shadow_count;
  logic [WORD_W-1:0] empty_word;

  int   send_idle_pct;
  int   recv_idle_pct;
  logic item_taken;
  logic hold_on;
  int   hold_count;
  int   error_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic push_entry(input logic [WORD_W-1:0] word);
    if (shadow_count < DEPTH) begin
      shadow_entries[shadow_tail] = word;
      shadow_tail = shadow_tail + 4'd1;
      shadow_count++;
    end
  endtask

  task automatic apply_queue_step(input item_t it);
    logic              first_valid;
    logic              second_valid;
    logic [WORD_W-1:0] first_data;
    logic              start_empty;
    result_t           res;
    first_valid  = it.write_valid_a | it.write_valid_b;
    second_valid = it.write_valid_a & it.write_valid_b;
    first_data   = it.write_valid_a ? it.write_data_a : it.write_data_b;
    start_empty  = (shadow_count == 0);
    if (it.update_enable) begin
      if (it.read_enable && !start_empty) begin
        shadow_head = shadow_head + 4'd1;
        shadow_count--;
      end
      if (first_valid && !(start_empty && it.read_enable)) push_entry(first_data);
      if (second_valid) push_entry(it.write_data_b);
    end
    if (start_empty && first_valid) res.read_data = first_data;
    else if (shadow_count == 0) res.read_data = empty_word;
    else res.read_data = shadow_entries[shadow_head];
    res.entry_count    = shadow_count[COUNT_W-1:0];
    res.is_full        = (shadow_count >= DEPTH);
    res.data_available = (shadow_count != 0) || first_valid;
    awaited_results.push_back(res);
  endtask

  // Prediction runs before the result check so that ordering within one edge
  // never matters.
  always @(posedge clk) begin
    if (rst) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= cmd_ch.valid && cmd_ch.ready;
      if (cmd_ch.valid && cmd_ch.ready) begin
        apply_queue_step('{cmd_ch.write_valid_a, cmd_ch.write_data_a, cmd_ch.write_valid_b,
                           cmd_ch.write_data_b, cmd_ch.read_enable, cmd_ch.update_enable});
      end
      if (result_ch.valid && result_ch.ready) begin
        if (awaited_results.size() == 0) begin
          flag_mismatch("unexpected result", result_ch.read_data, '0);
        end else begin
          result_t want;
          want = awaited_results.pop_front();
          if (result_ch.read_data !== want.read_data)
            flag_mismatch("read_data", result_ch.read_data, want.read_data);
          if (result_ch.entry_count !== want.entry_count)
            flag_mismatch("entry_count", WORD_W'(result_ch.entry_count),
                          WORD_W'(want.entry_count));
          if (result_ch.is_full !== want.is_full)
            flag_mismatch("is_full", WORD_W'(result_ch.is_full), WORD_W'(want.is_full));
          if (result_ch.data_available !== want.data_available)
            flag_mismatch("data_available", WORD_W'(result_ch.data_available),
                          WORD_W'(want.data_available));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst && (!cmd_ch.valid || item_taken)) begin
      if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item_t it;
        it = request_queue.pop_front();
        cmd_ch.valid         <= 1'b1;
        cmd_ch.write_valid_a <= it.write_valid_a;
        cmd_ch.write_data_a  <= it.write_data_a;
        cmd_ch.write_valid_b <= it.write_valid_b;
        cmd_ch.write_data_b  <= it.write_data_b;
        cmd_ch.read_enable   <= it.read_enable;
        cmd_ch.update_enable <= it.update_enable;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (hold_on && hold_count < HOLD_LEN) begin
        result_ch.ready <= 1'b0;
        hold_count      <= hold_count + 1;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        if (!hold_on) hold_count <= 0;
      end
    end
  end

  task automatic program_empty_value(input logic [WORD_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= EMPTY_VALUE_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    empty_word = value;
  endtask

  task automatic wait_drained();
    while (request_queue.size() != 0 || cmd_ch.valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic add_item(input logic va, input logic [WORD_W-1:0] da, input logic vb,
                          input logic [WORD_W-1:0] db, input logic rd, input logic upd);
    request_queue.push_back('{va, da, vb, db, rd, upd});
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    int sel;
    sel = $urandom_range(7);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return $urandom;
  endfunction

  task automatic queue_random_items(input int count);
    int write_pct;
    int read_pct;
    for (int n = 0; n < count; n++) begin
      if (n % CHUNK == 0) begin
        case ($urandom_range(3))
          0: begin write_pct = 85; read_pct = 20; end
          1: begin write_pct = 20; read_pct = 90; end
          2: begin write_pct = 50; read_pct = 50; end
          default: begin write_pct = $urandom_range(100); read_pct = $urandom_range(100); end
        endcase
      end
      add_item($urandom_range(99) < write_pct, pick_word(),
               $urandom_range(99) < write_pct, pick_word(),
               $urandom_range(99) < read_pct, $urandom_range(9) != 0);
    end
  endtask

  initial begin
    rst                  = 1'b1;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    cmd_ch.valid         = 1'b0;
    cmd_ch.write_valid_a = 1'b0;
    cmd_ch.write_data_a  = '0;
    cmd_ch.write_valid_b = 1'b0;
    cmd_ch.write_data_b  = '0;
    cmd_ch.read_enable   = 1'b0;
    cmd_ch.update_enable = 1'b0;
    result_ch.ready      = 1'b0;
    shadow_head          = '0;
    shadow_tail          = '0;
    shadow_count         = 0;
    empty_word           = '0;
    foreach (shadow_entries[i]) shadow_entries[i] = '0;
    send_idle_pct        = 0;
    recv_idle_pct        = 0;
    hold_on              = 1'b0;
    hold_count           = 0;
    error_count          = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    program_empty_value(32'h5A5A_C3C3);
    add_item(1'b0, '0, 1'b0, '0, 1'b1, 1'b1);
    add_item(1'b1, '1, 1'b0, '0, 1'b1, 1'b1);
    add_item(1'b1, '0, 1'b0, '1, 1'b0, 1'b0);
    add_item(1'b0, '1, 1'b1, 32'hA5A5_5A5A, 1'b0, 1'b1);
    add_item(1'b1, 32'h1111_0000, 1'b1, 32'h2222_0000, 1'b1, 1'b0);
    for (int k = 0; k < 7; k++)
      add_item(1'b1, 32'h0000_0100 + k, 1'b1, 32'hFFFF_0100 + k, 1'b0, 1'b1);
    add_item(1'b1, '1, 1'b1, '0, 1'b0, 1'b1);
    add_item(1'b0, '0, 1'b1, 32'hDEAD_0001, 1'b0, 1'b1);
    add_item(1'b1, 32'h3333_3333, 1'b1, 32'h4444_4444, 1'b1, 1'b1);
    add_item(1'b0, '0, 1'b0, '0, 1'b1, 1'b0);
    add_item(1'b1, 32'h5555_5555, 1'b0, '0, 1'b1, 1'b1);
    for (int k = 0; k < 3; k++) add_item(1'b0, '0, 1'b0, '0, 1'b1, 1'b1);
    wait_drained();

    program_empty_value('1);
    send_idle_pct = 26;
    recv_idle_pct = 79;
    queue_random_items(300);
    wait_drained();

    program_empty_value($urandom);
    send_idle_pct = 79;
    recv_idle_pct = 26;
    queue_random_items(300);
    wait_drained();

    program_empty_value('0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_items(300);
    hold_on = 1'b1;
    wait (hold_count == HOLD_LEN);
    hold_on = 1'b0;
    wait_drained();

    if (awaited_results.size() != 0)
      flag_mismatch("missing results", WORD_W'(awaited_results.size()), '0);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
